FILE: rtl/tanc_pkg.sv
`default_nettype none
package tanc_pkg;
  localparam logic [2:0] MODE_IDLE   = 3'd0;
  localparam logic [2:0] MODE_LEAD   = 3'd1;
  localparam logic [2:0] MODE_ACK    = 3'd2;
  localparam logic [2:0] MODE_ASSIGN = 3'd3;
  localparam logic [2:0] MODE_ACTIVE = 3'd4;
  localparam logic [2:0] MODE_QUIET  = 3'd5;
  localparam logic [2:0] MODE_SAFE   = 3'd6;

  localparam logic [1:0] FN_TICK     = 2'd0;
  localparam logic [1:0] FN_MSG      = 2'd1;
  localparam logic [1:0] FN_START    = 2'd2;
  localparam logic [1:0] FN_COMPLETE = 2'd3;

  localparam logic [1:0] MT_REQUEST = 2'd0;
  localparam logic [1:0] MT_CAND    = 2'd1;
  localparam logic [1:0] MT_ACK     = 2'd2;
  localparam logic [1:0] MT_ASSIGN  = 2'd3;

  localparam logic [2:0] REG_OWN     = 3'd0;
  localparam logic [2:0] REG_EPOCH   = 3'd1;
  localparam logic [2:0] REG_NODES   = 3'd2;
  localparam logic [2:0] REG_WINDOW  = 3'd3;
  localparam logic [2:0] REG_RETRY   = 3'd4;
  localparam logic [2:0] REG_ATTEMPT = 3'd5;
  localparam logic [2:0] REG_FAIL    = 3'd6;

  localparam logic [7:0] BCAST = 8'd255;
  localparam logic [15:0] SEQ_MAX = 16'hFFFF;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] now_ms;
    logic [1:0]  health;
    logic [1:0]  msg_type;
    logic [7:0]  sender;
    logic [7:0]  target;
    logic [7:0]  key_origin;
    logic [15:0] key_epoch;
    logic [15:0] key_sequence;
    logic [7:0]  score;
    logic        fields_valid;
    logic        tx_ready;
  } in_word_t;

  typedef struct packed {
    logic        send_valid;
    logic [1:0]  send_type;
    logic [7:0]  send_target;
    logic [7:0]  send_origin;
    logic [15:0] send_epoch;
    logic [15:0] send_sequence;
    logic [7:0]  send_score;
    logic [2:0]  ctrl_state;
    logic [7:0]  assigned;
    logic        accepted;
  } out_word_t;

  typedef struct packed {
    logic [2:0]  idx;
    logic [31:0] data;
  } cfg_word_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_step;
    logic finish;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_scan;
    logic scan_last;
  } dp_sts_t;
endpackage
`default_nettype wire

FILE: rtl/tanc_if.sv
`default_nettype none
interface tanc_in_if;
  logic valid;
  logic ready;
  tanc_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tanc_out_if;
  logic valid;
  logic ready;
  tanc_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tanc_cfg_if;
  logic valid;
  logic ready;
  tanc_pkg::cfg_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/tanc_ctrl.sv
`default_nettype none
module tanc_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output tanc_pkg::dp_cmd_t    cmd,
  input  wire tanc_pkg::dp_sts_t sts
);
  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FIN, S_OUT} st_t;
  st_t st_r;

  assign in_ready  = (st_r == S_IDLE);
  assign out_valid = (st_r == S_OUT);

  always_comb begin
    cmd = '0;
    cmd.load       = (st_r == S_IDLE) && in_valid;
    cmd.scan_start = cmd.load;
    cmd.scan_step  = (st_r == S_SCAN);
    cmd.finish     = (st_r == S_FIN);
  end

  // sequence: load, optional winner scan, finish, hand off word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      case (st_r)
        S_IDLE: if (in_valid) st_r <= S_SCAN;
        S_SCAN: if (!sts.need_scan || sts.scan_last) st_r <= S_FIN;
        S_FIN:  st_r <= S_OUT;
        S_OUT:  if (out_ready) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: rtl/tanc_dp.sv
`default_nettype none
module tanc_dp #(
  parameter int MAX_NODES = 16,
  parameter int MAX_SCORE = 100
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire tanc_pkg::in_word_t   in_data,
  input  wire logic                 cfg_we,
  input  wire tanc_pkg::cfg_word_t  cfg_data,
  input  wire tanc_pkg::dp_cmd_t    cmd,
  output tanc_pkg::dp_sts_t         sts,
  output tanc_pkg::out_word_t       out_data
);
  localparam int NW = $clog2(MAX_NODES);
  localparam logic [7:0] MAXN8 = 8'(MAX_NODES);
  localparam logic [7:0] MAXS8 = 8'(MAX_SCORE);

  // configuration
  logic [7:0]  own_r;
  logic [15:0] epoch_r;
  logic [4:0]  nodes_r;
  logic [31:0] window_r, retry_r;
  logic [7:0]  alim_r, flim_r;

  // state
  logic [2:0]  mode_r;
  logic [MAX_NODES-1:0] seen_r;
  logic [7:0]  bscore_r [MAX_NODES];
  logic [7:0]  corg_r;
  logic [15:0] cep_r, cseq_r, nseq_r;
  logic [7:0]  att_r, fail_r, asg_r;
  logic [31:0] pstart_r, lastatt_r;
  tanc_pkg::in_word_t in_r;
  tanc_pkg::out_word_t out_r;

  // scan registers
  logic [NW:0] idx_r;
  logic [NW-1:0] best_r;

  logic [7:0] n_eff;
  always_comb begin
    if (nodes_r == 5'd0 || 8'(nodes_r) > MAXN8) n_eff = MAXN8;
    else n_eff = 8'(nodes_r);
  end
  logic cfg_bad;
  assign cfg_bad = (own_r >= n_eff) || (epoch_r == 16'd0);
  logic [2:0] mode0;
  assign mode0 = cfg_bad ? tanc_pkg::MODE_SAFE : mode_r;

  logic lead_expire;
  assign lead_expire = (in_r.func == tanc_pkg::FN_TICK) && (in_r.health == 2'd0) &&
                       (mode0 == tanc_pkg::MODE_LEAD) &&
                       ((in_r.now_ms - pstart_r) >= window_r);
  assign sts.need_scan = lead_expire;
  assign sts.scan_last = (idx_r + 1'b1) >= (NW+1)'(n_eff);

  logic [NW-1:0] own_ix;
  assign own_ix = NW'(own_r);
  logic own_inr;
  assign own_inr = own_r < MAXN8;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_r <= 8'd0; epoch_r <= 16'd1; nodes_r <= 5'd16;
      window_r <= 32'd1000; retry_r <= 32'd200; alim_r <= 8'd3; flim_r <= 8'd3;
    end else if (cfg_we) begin
      case (cfg_data.idx)
        tanc_pkg::REG_OWN:     own_r <= cfg_data.data[7:0];
        tanc_pkg::REG_EPOCH:   epoch_r <= cfg_data.data[15:0];
        tanc_pkg::REG_NODES:   nodes_r <= cfg_data.data[4:0];
        tanc_pkg::REG_WINDOW:  window_r <= cfg_data.data;
        tanc_pkg::REG_RETRY:   retry_r <= cfg_data.data;
        tanc_pkg::REG_ATTEMPT: alim_r <= cfg_data.data[7:0];
        tanc_pkg::REG_FAIL:    flim_r <= cfg_data.data[7:0];
        default: ;
      endcase
    end
  end

  // winner scan, one bid entry a cycle
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      idx_r  <= '0;
      best_r <= own_inr ? own_ix : '0;
    end else if (cmd.scan_step && sts.need_scan) begin
      if (seen_r[idx_r[NW-1:0]] && bscore_r[idx_r[NW-1:0]] > bscore_r[best_r])
        best_r <= idx_r[NW-1:0];
      if (!sts.scan_last) idx_r <= idx_r + 1'b1;
    end
  end

  // item update
  always_ff @(posedge clk) begin
    logic [2:0] m;
    logic [7:0] att, fail, asg, ownbid, alim, flim;
    logic sv, acc, same, msg_ok;
    tanc_pkg::out_word_t o;
    if (!rst_n) begin
      mode_r <= tanc_pkg::MODE_IDLE;
      seen_r <= '0;
      for (int i = 0; i < MAX_NODES; i++) bscore_r[i] <= 8'd0;
      corg_r <= '0; cep_r <= '0; cseq_r <= '0; nseq_r <= 16'd1;
      att_r <= '0; fail_r <= '0; pstart_r <= '0; lastatt_r <= '0;
      asg_r <= tanc_pkg::BCAST;
    end else begin
      if (cmd.load) in_r <= in_data;
      if (cmd.finish) begin
        m = mode0; att = att_r; fail = fail_r; asg = asg_r;
        sv = 1'b0; acc = 1'b0; o = '0;
        ownbid = own_inr ? bscore_r[own_ix] : 8'd0;
        alim = (alim_r == 8'd0) ? 8'd1 : alim_r;
        flim = (flim_r == 8'd0) ? 8'd1 : flim_r;
        same = in_r.key_origin == corg_r && in_r.key_epoch == cep_r &&
               in_r.key_sequence == cseq_r;
        msg_ok = !(m == tanc_pkg::MODE_SAFE || m == tanc_pkg::MODE_QUIET) &&
                 in_r.sender < n_eff && in_r.sender != own_r &&
                 in_r.key_origin < n_eff && in_r.fields_valid;
        case (in_r.func)
          tanc_pkg::FN_TICK: begin
            if (in_r.health >= 2'd2) m = tanc_pkg::MODE_SAFE;
            else if (m == tanc_pkg::MODE_SAFE) m = m;
            else if (in_r.health == 2'd1) m = tanc_pkg::MODE_QUIET;
            else begin
              if (m == tanc_pkg::MODE_QUIET) m = tanc_pkg::MODE_IDLE;
              if (lead_expire) begin
                if (in_r.tx_ready) begin
                  sv = 1'b1; o.send_type = tanc_pkg::MT_ASSIGN;
                  o.send_target = 8'(best_r); o.send_origin = corg_r;
                  o.send_epoch = cep_r; o.send_sequence = cseq_r;
                  asg = 8'(best_r);
                  m = (8'(best_r) == own_r) ? tanc_pkg::MODE_ACTIVE : tanc_pkg::MODE_IDLE;
                end else begin
                  asg = tanc_pkg::BCAST; m = tanc_pkg::MODE_IDLE;
                end
              end else if (m == tanc_pkg::MODE_ACK &&
                           (in_r.now_ms - lastatt_r) >= retry_r) begin
                if (att >= alim) begin
                  if (fail != 8'd255) fail = fail + 8'd1;
                  m = (fail >= flim) ? tanc_pkg::MODE_SAFE : tanc_pkg::MODE_IDLE;
                end else begin
                  if (in_r.tx_ready) begin
                    sv = 1'b1; o.send_type = tanc_pkg::MT_CAND;
                    o.send_target = corg_r; o.send_origin = corg_r;
                    o.send_epoch = cep_r; o.send_sequence = cseq_r; o.send_score = ownbid;
                    m = tanc_pkg::MODE_ACK;
                  end
                  if (att != 8'd255) att = att + 8'd1;
                  lastatt_r <= in_r.now_ms;
                end
              end else if (m == tanc_pkg::MODE_ASSIGN &&
                           (in_r.now_ms - pstart_r) >= window_r) begin
                m = tanc_pkg::MODE_IDLE;
              end
            end
          end
          tanc_pkg::FN_MSG: if (msg_ok) begin
            case (in_r.msg_type)
              tanc_pkg::MT_REQUEST: begin
                if (in_r.target == tanc_pkg::BCAST && in_r.sender == in_r.key_origin &&
                    m == tanc_pkg::MODE_IDLE && own_r < n_eff) begin
                  corg_r <= in_r.key_origin; cep_r <= in_r.key_epoch;
                  cseq_r <= in_r.key_sequence;
                  pstart_r <= in_r.now_ms; lastatt_r <= in_r.now_ms;
                  ownbid = (in_r.score > MAXS8) ? MAXS8 : in_r.score;
                  bscore_r[own_ix] <= ownbid;
                  att = 8'd1;
                  if (in_r.tx_ready) begin
                    sv = 1'b1; o.send_type = tanc_pkg::MT_CAND;
                    o.send_target = in_r.key_origin; o.send_origin = in_r.key_origin;
                    o.send_epoch = in_r.key_epoch; o.send_sequence = in_r.key_sequence;
                    o.send_score = ownbid;
                    m = tanc_pkg::MODE_ACK;
                  end
                end
              end
              tanc_pkg::MT_CAND: begin
                if (m == tanc_pkg::MODE_LEAD && in_r.target == own_r && same &&
                    in_r.score <= MAXS8) begin
                  seen_r[NW'(in_r.sender)] <= 1'b1;
                  bscore_r[NW'(in_r.sender)] <= in_r.score;
                  if (in_r.tx_ready) begin
                    sv = 1'b1; o.send_type = tanc_pkg::MT_ACK;
                    o.send_target = in_r.sender; o.send_origin = in_r.key_origin;
                    o.send_epoch = in_r.key_epoch; o.send_sequence = in_r.key_sequence;
                  end
                end
              end
              tanc_pkg::MT_ACK: begin
                if (m == tanc_pkg::MODE_ACK && in_r.target == own_r && same &&
                    in_r.sender == corg_r) begin
                  fail = 8'd0; pstart_r <= in_r.now_ms; m = tanc_pkg::MODE_ASSIGN;
                end
              end
              default: begin
                if ((m == tanc_pkg::MODE_ACK || m == tanc_pkg::MODE_ASSIGN) &&
                    in_r.target < n_eff && same && in_r.sender == corg_r) begin
                  fail = 8'd0; asg = in_r.target;
                  m = (in_r.target == own_r) ? tanc_pkg::MODE_ACTIVE : tanc_pkg::MODE_IDLE;
                end
              end
            endcase
          end
          tanc_pkg::FN_START: begin
            if (m == tanc_pkg::MODE_IDLE && !cfg_bad && nseq_r != 16'd0 &&
                in_r.fields_valid && in_r.tx_ready) begin
              sv = 1'b1; acc = 1'b1; o.send_type = tanc_pkg::MT_REQUEST;
              o.send_target = tanc_pkg::BCAST; o.send_origin = own_r;
              o.send_epoch = epoch_r; o.send_sequence = nseq_r;
              corg_r <= own_r; cep_r <= epoch_r; cseq_r <= nseq_r;
              nseq_r <= (nseq_r == tanc_pkg::SEQ_MAX) ? 16'd0 : nseq_r + 16'd1;
              for (int i = 0; i < MAX_NODES; i++) begin
                seen_r[i] <= (NW'(i) == own_ix);
                bscore_r[i] <= (NW'(i) == own_ix) ?
                               ((in_r.score > MAXS8) ? MAXS8 : in_r.score) : 8'd0;
              end
              asg = tanc_pkg::BCAST; pstart_r <= in_r.now_ms;
              m = tanc_pkg::MODE_LEAD;
            end
          end
          default: begin
            if (m == tanc_pkg::MODE_ACTIVE) begin
              asg = tanc_pkg::BCAST; m = tanc_pkg::MODE_IDLE;
            end
          end
        endcase
        o.send_valid = sv; o.ctrl_state = m; o.assigned = asg; o.accepted = acc;
        mode_r <= m; att_r <= att; fail_r <= fail; asg_r <= asg;
        out_r <= o;
      end
    end
  end

  assign out_data = out_r;
endmodule
`default_nettype wire

FILE: rtl/task_auction_node_controller_core.sv
// Task auction node controller core.
// Channels: in (one word per item: tick, message, start, complete), out
// (one result word per item), cfg (register index and data; the user must
// write it only while idle, the block does not enforce this; always ready).
// Sequence: an item is taken, then scanned, finished and shown on out.
// The result word is registered by the finish step. An expiring leader
// tick scans one bid entry a cycle over the effective node count before
// its finish step. One item is in flight at a time; in_ready is high
// only between items and the next word is taken the cycle after the
// result word leaves.
// Reset (rst_n low, synchronous) restores register defaults and clears all
// auction state, mode idle.
// When out_ready is low the result word holds and no new item is taken.
`default_nettype none
module task_auction_node_controller_core #(
  parameter int MAX_NODES = 16,
  parameter int MAX_SCORE = 100
) (
  input wire logic clk,
  input wire logic rst_n,
  tanc_in_if.sink    in_ch,
  tanc_out_if.source out_ch,
  tanc_cfg_if.sink   cfg_ch
);
  tanc_pkg::dp_cmd_t cmd;
  tanc_pkg::dp_sts_t sts;

  assign cfg_ch.ready = 1'b1;

  tanc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd(cmd), .sts(sts)
  );

  tanc_dp #(.MAX_NODES(MAX_NODES), .MAX_SCORE(MAX_SCORE)) u_dp (
    .clk(clk), .rst_n(rst_n),
    .in_data(in_ch.data),
    .cfg_we(cfg_ch.valid), .cfg_data(cfg_ch.data),
    .cmd(cmd), .sts(sts),
    .out_data(out_ch.data)
  );
endmodule
`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import tanc_pkg::*;

  localparam int MAX_NODES = 16;
  localparam int MAX_SCORE = 100;
  localparam int CYCLE_LIMIT = 5000000;

  logic clk;
  logic rst_n;

  tanc_in_if  in_ch ();
  tanc_out_if out_ch ();
  tanc_cfg_if cfg_ch ();

  task_auction_node_controller_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  // register shadow
  logic [7:0]  c_own;
  logic [15:0] c_epoch;
  logic [4:0]  c_nodes;
  logic [31:0] c_window;
  logic [31:0] c_retry;
  logic [7:0]  c_attempts;
  logic [7:0]  c_fail_lim;

  // node state shadow
  logic [2:0]  p_mode;
  bit          p_seen [MAX_NODES];
  logic [7:0]  p_bid [MAX_NODES];
  logic [7:0]  p_org;
  logic [15:0] p_ep;
  logic [15:0] p_seq;
  logic [15:0] p_next;
  logic [7:0]  p_tries;
  logic [7:0]  p_fails;
  logic [31:0] p_start;
  logic [31:0] p_last;
  logic [7:0]  p_asg;
  out_word_t   res;

  in_word_t  word_q [$];
  out_word_t due_results [$];
  int pushed;
  int taken;
  int outstanding;
  int errors;
  int cycles;
  int in_gap;
  int out_gap;
  bit calm;
  logic [31:0] t_now;

  function automatic int live_nodes();
    return (c_nodes == 0 || c_nodes > MAX_NODES) ? MAX_NODES : int'(c_nodes);
  endfunction

  function automatic logic [7:0] cap_score(logic [7:0] s);
    return (s > MAX_SCORE) ? 8'(MAX_SCORE) : s;
  endfunction

  function automatic void reset_node();
    c_own = 8'd0;
    c_epoch = 16'd1;
    c_nodes = 5'd16;
    c_window = 32'd1000;
    c_retry = 32'd200;
    c_attempts = 8'd3;
    c_fail_lim = 8'd3;
    for (int i = 0; i < MAX_NODES; i++) begin
      p_seen[i] = 0;
      p_bid[i] = '0;
    end
    p_org = '0;
    p_ep = '0;
    p_seq = '0;
    p_next = 16'd1;
    p_tries = '0;
    p_fails = '0;
    p_start = '0;
    p_last = '0;
    p_asg = BCAST;
    p_mode = MODE_IDLE;
  endfunction

  function automatic void apply_reg(logic [2:0] idx, logic [31:0] val);
    case (idx)
      REG_OWN:     c_own = val[7:0];
      REG_EPOCH:   c_epoch = val[15:0];
      REG_NODES:   c_nodes = val[4:0];
      REG_WINDOW:  c_window = val;
      REG_RETRY:   c_retry = val;
      REG_ATTEMPT: c_attempts = val[7:0];
      REG_FAIL:    c_fail_lim = val[7:0];
      default: ;
    endcase
  endfunction

  // put a message on the wire if the link takes it
  function automatic bit transmit(bit rdy, logic [1:0] t, logic [7:0] tg, logic [7:0] o,
                                  logic [15:0] e, logic [15:0] s, logic [7:0] sc);
    if (!rdy) return 0;
    res.send_valid = 1'b1;
    res.send_type = t;
    res.send_target = tg;
    res.send_origin = o;
    res.send_epoch = e;
    res.send_sequence = s;
    res.send_score = sc;
    return 1;
  endfunction

  function automatic void send_bid(bit rdy, logic [31:0] now);
    logic [7:0] mine;
    mine = (c_own < MAX_NODES) ? p_bid[c_own[3:0]] : 8'd0;
    if (transmit(rdy, MT_CAND, p_org, p_org, p_ep, p_seq, mine)) p_mode = MODE_ACK;
    if (p_tries < 8'd255) p_tries++;
    p_last = now;
  endfunction

  // pick the winner: highest bid, own node by default and on ties with it, else earliest node on ties
  function automatic void close_auction(bit rdy);
    int n;
    int pick;
    n = live_nodes();
    pick = int'(c_own);
    if (pick >= MAX_NODES) pick = 0;
    for (int c = 0; c < n; c++) begin
      if (p_seen[c] && p_bid[c] > p_bid[pick]) pick = c;
    end
    if (!transmit(rdy, MT_ASSIGN, 8'(pick), p_org, p_ep, p_seq, 8'd0)) begin
      p_asg = BCAST;
      p_mode = MODE_IDLE;
    end else begin
      p_asg = 8'(pick);
      p_mode = (pick == int'(c_own)) ? MODE_ACTIVE : MODE_IDLE;
    end
  endfunction

  function automatic void on_tick(in_word_t w);
    logic [31:0] since_start;
    logic [31:0] since_try;
    logic [7:0] lim;
    logic [7:0] flim;
    since_start = w.now_ms - p_start;
    since_try = w.now_ms - p_last;
    lim = (c_attempts == 0) ? 8'd1 : c_attempts;
    flim = (c_fail_lim == 0) ? 8'd1 : c_fail_lim;
    if (w.health >= 2) begin
      p_mode = MODE_SAFE;
    end else if (p_mode != MODE_SAFE) begin
      if (w.health == 1) begin
        p_mode = MODE_QUIET;
      end else begin
        if (p_mode == MODE_QUIET) p_mode = MODE_IDLE;
        if (p_mode == MODE_LEAD && since_start >= c_window) begin
          close_auction(w.tx_ready);
        end else if (p_mode == MODE_ACK && since_try >= c_retry) begin
          if (p_tries >= lim) begin
            if (p_fails < 8'd255) p_fails++;
            p_mode = (p_fails >= flim) ? MODE_SAFE : MODE_IDLE;
          end else begin
            send_bid(w.tx_ready, w.now_ms);
          end
        end else if (p_mode == MODE_ASSIGN && since_start >= c_window) begin
          p_mode = MODE_IDLE;
        end
      end
    end
  endfunction

  function automatic void on_message(in_word_t w);
    int n;
    bit same;
    n = live_nodes();
    same = (w.key_origin == p_org && w.key_epoch == p_ep && w.key_sequence == p_seq);
    if (p_mode == MODE_SAFE || p_mode == MODE_QUIET) return;
    if (w.sender >= n || w.sender == c_own || w.key_origin >= n || !w.fields_valid) return;
    case (w.msg_type)
      MT_REQUEST: begin
        if (w.target == BCAST && w.sender == w.key_origin && p_mode == MODE_IDLE &&
            c_own < n) begin
          p_org = w.key_origin;
          p_ep = w.key_epoch;
          p_seq = w.key_sequence;
          p_tries = '0;
          p_start = w.now_ms;
          p_bid[c_own[3:0]] = cap_score(w.score);
          send_bid(w.tx_ready, w.now_ms);
        end
      end
      MT_CAND: begin
        if (p_mode == MODE_LEAD && w.target == c_own && same && w.score <= MAX_SCORE) begin
          p_seen[w.sender[3:0]] = 1;
          p_bid[w.sender[3:0]] = w.score;
          void'(transmit(w.tx_ready, MT_ACK, w.sender, w.key_origin, w.key_epoch,
                         w.key_sequence, 8'd0));
        end
      end
      MT_ACK: begin
        if (p_mode == MODE_ACK && w.target == c_own && same && w.sender == p_org) begin
          p_fails = '0;
          p_start = w.now_ms;
          p_mode = MODE_ASSIGN;
        end
      end
      default: begin
        if ((p_mode == MODE_ACK || p_mode == MODE_ASSIGN) && w.target < n && same &&
            w.sender == p_org) begin
          p_fails = '0;
          p_asg = w.target;
          p_mode = (w.target == c_own) ? MODE_ACTIVE : MODE_IDLE;
        end
      end
    endcase
  endfunction

  function automatic bit on_start(in_word_t w);
    if (!(p_mode == MODE_IDLE && c_own < live_nodes() && p_next != 0 && w.fields_valid))
      return 0;
    if (!transmit(w.tx_ready, MT_REQUEST, BCAST, c_own, c_epoch, p_next, 8'd0)) return 0;
    p_org = c_own;
    p_ep = c_epoch;
    p_seq = p_next;
    p_next = (p_next == SEQ_MAX) ? 16'd0 : p_next + 16'd1;
    for (int i = 0; i < MAX_NODES; i++) begin
      p_seen[i] = 0;
      p_bid[i] = '0;
    end
    p_seen[c_own[3:0]] = 1;
    p_bid[c_own[3:0]] = cap_score(w.score);
    p_asg = BCAST;
    p_start = w.now_ms;
    p_mode = MODE_LEAD;
    return 1;
  endfunction

  // compute the result word of one item and advance the shadow state
  function automatic out_word_t auction_step(in_word_t w);
    bit acc;
    acc = 0;
    res = '0;
    if (c_own >= live_nodes() || c_epoch == 0) p_mode = MODE_SAFE;
    case (w.func)
      FN_TICK:  on_tick(w);
      FN_MSG:   on_message(w);
      FN_START: acc = on_start(w);
      default: begin
        if (p_mode == MODE_ACTIVE) begin
          p_asg = BCAST;
          p_mode = MODE_IDLE;
        end
      end
    endcase
    res.ctrl_state = p_mode;
    res.assigned = p_asg;
    res.accepted = acc;
    return res;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
  endtask

  task automatic check_result(out_word_t got);
    out_word_t want;
    if (due_results.size() == 0) begin
      report("result with none pending", got.ctrl_state, 0);
    end else begin
      want = due_results.pop_front();
      outstanding--;
      if (got.send_valid !== want.send_valid)
        report("send_valid", got.send_valid, want.send_valid);
      if (got.send_type !== want.send_type) report("send_type", got.send_type, want.send_type);
      if (got.send_target !== want.send_target)
        report("send_target", got.send_target, want.send_target);
      if (got.send_origin !== want.send_origin)
        report("send_origin", got.send_origin, want.send_origin);
      if (got.send_epoch !== want.send_epoch)
        report("send_epoch", got.send_epoch, want.send_epoch);
      if (got.send_sequence !== want.send_sequence)
        report("send_sequence", got.send_sequence, want.send_sequence);
      if (got.send_score !== want.send_score)
        report("send_score", got.send_score, want.send_score);
      if (got.ctrl_state !== want.ctrl_state)
        report("ctrl_state", got.ctrl_state, want.ctrl_state);
      if (got.assigned !== want.assigned) report("assigned", got.assigned, want.assigned);
      if (got.accepted !== want.accepted) report("accepted", got.accepted, want.accepted);
    end
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** task_auction_node_controller_core: FAILED **");
      $finish;
    end
  end

  // driver: present queued words, predict each accepted one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        due_results.push_back(auction_step(in_ch.data));
        outstanding++;
        taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_ch.valid <= 1'b0;
        end else if (word_q.size() > 0) begin
          in_ch.valid <= 1'b1;
          in_ch.data <= word_q.pop_front();
          if (!calm && $urandom_range(0, 9) == 0) in_gap = $urandom_range(1, 17);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: stall at random, check every accepted result word
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_result(out_ch.data);
      if (out_gap > 0) begin
        out_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (!calm && $urandom_range(0, 11) == 0) out_gap = $urandom_range(1, 17);
      end
    end
  end

  function automatic in_word_t mk(logic [1:0] f, logic [31:0] now, logic [1:0] hl,
                                  logic [1:0] mt, logic [7:0] snd, logic [7:0] tg,
                                  logic [7:0] ko, logic [15:0] ke, logic [15:0] ks,
                                  logic [7:0] sc, logic fv, logic tx);
    in_word_t w;
    w.func = f;
    w.now_ms = now;
    w.health = hl;
    w.msg_type = mt;
    w.sender = snd;
    w.target = tg;
    w.key_origin = ko;
    w.key_epoch = ke;
    w.key_sequence = ks;
    w.score = sc;
    w.fields_valid = fv;
    w.tx_ready = tx;
    return w;
  endfunction

  task automatic push_word(in_word_t w);
    word_q.push_back(w);
    pushed++;
  endtask

  // wait until the block has nothing in flight
  task automatic drain();
    wait (taken == pushed && outstanding == 0);
    repeat (MAX_NODES + 8) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= '{idx: idx, data: val};
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    apply_reg(idx, val);
  endtask

  task automatic set_config(logic [7:0] own, logic [15:0] ep, logic [4:0] nodes,
                            logic [31:0] win, logic [31:0] retry, logic [7:0] att,
                            logic [7:0] flim);
    drain();
    @(posedge clk);
    write_reg(REG_NODES, 32'(nodes));
    write_reg(REG_OWN, 32'(own));
    write_reg(REG_EPOCH, 32'(ep));
    write_reg(REG_WINDOW, win);
    write_reg(REG_RETRY, retry);
    write_reg(REG_ATTEMPT, 32'(att));
    write_reg(REG_FAIL, 32'(flim));
    cfg_ch.valid <= 1'b0;
  endtask

  // random peer below node count other than this node, -1 if none
  function automatic int pick_peer();
    int n;
    int p;
    n = live_nodes();
    if (n < 2 || c_own >= n) return -1;
    p = $urandom_range(0, n - 2);
    if (p >= int'(c_own)) p++;
    return p;
  endfunction

  // build one word that fits what the node is doing now, with some noise
  task automatic gen_word(bit fatal_ok);
    in_word_t w;
    int r;
    int peer;
    int n;
    n = live_nodes();
    r = $urandom_range(0, 99);
    peer = pick_peer();
    case ($urandom_range(0, 24))
      0:       t_now = $urandom;
      1, 2:    t_now += c_window + $urandom_range(0, 3);
      3, 4:    t_now += c_retry + $urandom_range(0, 3);
      default: t_now += $urandom_range(0, 150);
    endcase
    w = mk(FN_TICK, t_now, 2'd0, MT_REQUEST, 8'd0, c_own, p_org, p_ep, p_seq,
           8'($urandom), 1'b1, 1'($urandom_range(0, 9) != 0));
    if (r < 12 || peer < 0 && p_mode != MODE_ACTIVE && r < 50) begin
      w = in_word_t'(104'({$urandom, $urandom, $urandom, $urandom}));
    end else begin
      case (p_mode)
        MODE_IDLE: begin
          if (r < 45) begin
            w.func = FN_START;
          end else if (r < 80) begin
            w.func = FN_MSG;
            w.sender = 8'(peer);
            w.target = BCAST;
            w.key_origin = 8'(peer);
            w.key_epoch = 16'($urandom);
            w.key_sequence = 16'($urandom);
          end
        end
        MODE_LEAD: begin
          if (r < 70) begin
            w.func = FN_MSG;
            w.msg_type = MT_CAND;
            w.sender = 8'(peer);
            w.score = 8'($urandom_range(0, 110));
          end
        end
        MODE_ACK, MODE_ASSIGN: begin
          if (r < 60) begin
            w.func = FN_MSG;
            w.sender = p_org;
            w.msg_type = (p_mode == MODE_ACK && r < 40) ? MT_ACK : MT_ASSIGN;
            if (w.msg_type == MT_ASSIGN && $urandom_range(0, 1) == 0)
              w.target = 8'($urandom_range(0, n - 1));
          end
        end
        MODE_ACTIVE: begin
          if (r < 50) w.func = FN_COMPLETE;
          else if (r < 58) w.func = FN_START;
        end
        default: ;
      endcase
      // break a well-formed word now and then
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 3))
          0: w.fields_valid = 1'b0;
          1: w.key_sequence ^= 16'd1;
          2: w.sender = c_own;
          default: w.target = 8'($urandom);
        endcase
      end
      if (w.func == FN_TICK && $urandom_range(0, 19) == 0) w.health = 2'd1;
    end
    if (w.func == FN_TICK && w.health >= 2) begin
      if (!fatal_ok || $urandom_range(0, 9) != 0) w.health[1] = 1'b0;
    end
    push_word(w);
    wait (taken == pushed);
  endtask

  task automatic run_random(int count, bit fatal_ok);
    for (int i = 0; i < count; i++) gen_word(fatal_ok);
  endtask

  task automatic directed();
    // leading: refused starts, then an auction with ties and bad bids
    push_word(mk(FN_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1));
    push_word(mk(FN_START, 5, 0, 0, 0, 0, 0, 0, 0, 50, 0, 1));
    push_word(mk(FN_START, 6, 0, 0, 0, 0, 0, 0, 0, 50, 1, 0));
    push_word(mk(FN_START, 10, 0, 0, 0, 0, 0, 0, 0, 50, 1, 1));
    push_word(mk(FN_MSG, 20, 0, MT_CAND, 3, 0, 0, 1, 1, 101, 1, 1));
    push_word(mk(FN_MSG, 30, 0, MT_CAND, 3, 0, 0, 1, 1, 100, 1, 0));
    push_word(mk(FN_MSG, 40, 0, MT_CAND, 5, 0, 0, 1, 1, 100, 1, 1));
    push_word(mk(FN_MSG, 50, 0, MT_CAND, 0, 0, 0, 1, 1, 90, 1, 1));
    push_word(mk(FN_MSG, 60, 0, MT_CAND, 200, 0, 0, 1, 1, 90, 1, 1));
    push_word(mk(FN_TICK, 1009, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1));
    push_word(mk(FN_TICK, 1010, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1));
    push_word(mk(FN_COMPLETE, 1020, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1));
    // bidding: request, acknowledgement, assignment, completion
    push_word(mk(FN_MSG, 1100, 0, MT_REQUEST, 2, BCAST, 2, 7, 9, 255, 1, 1));
    push_word(mk(FN_MSG, 1110, 0, MT_ACK, 2, 0, 2, 7, 9, 0, 1, 1));
    push_word(mk(FN_MSG, 1120, 0, MT_ASSIGN, 2, 0, 2, 7, 9, 0, 1, 1));
    push_word(mk(FN_COMPLETE, 1130, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1));
    // failed send of a candidacy, then a corrupt request
    push_word(mk(FN_MSG, 1200, 0, MT_REQUEST, 4, BCAST, 4, 1, 2, 30, 1, 0));
    push_word(mk(FN_MSG, 1210, 0, MT_REQUEST, 4, BCAST, 4, 1, 2, 30, 0, 1));
    // quiescent overrides, messages ignored meanwhile
    push_word(mk(FN_TICK, 1300, 1, 0, 0, 0, 0, 0, 0, 0, 1, 1));
    push_word(mk(FN_MSG, 1310, 0, MT_REQUEST, 4, BCAST, 4, 1, 2, 30, 1, 1));
    push_word(mk(FN_TICK, 1320, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1));
    // retry path: candidacy then retransmissions until abandoned
    push_word(mk(FN_MSG, 1400, 0, MT_REQUEST, 6, BCAST, 6, 3, 3, 40, 1, 1));
    push_word(mk(FN_TICK, 1600, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1));
    push_word(mk(FN_TICK, 1800, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1));
    push_word(mk(FN_TICK, 2000, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1));
    t_now = 2000;
  endtask

  initial begin
    int burn;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    calm = 0;
    reset_node();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    directed();
    drain();
    run_random(120, 0);

    set_config(5, 16'hFFFF, 8, 0, 0, 1, 255);
    run_random(140, 0);
    drain();
    run_random(140, 0);
    set_config(15, 16'h1234, 16, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 255, 255);
    run_random(200, 0);
    set_config(2, 16'h0007, 3, 50, 10, 2, 255);
    run_random(280, 0);
    set_config(0, 16'h0001, 2, 300, 60, 4, 255);
    run_random(280, 0);
    set_config(9, 16'h8000, 12, 120, 30, 3, 255);
    run_random(280, 0);
    set_config(0, 16'h5A5A, 1, 20, 5, 2, 255);
    run_random(60, 0);

    // back-to-back starts, each closed by an expiring tick with a failed send
    set_config(0, 16'h0101, 1, 0, 0, 3, 255);
    calm = 1;
    push_word(mk(FN_TICK, t_now, 1, 0, 0, 0, 0, 0, 0, 0, 1, 1));
    push_word(mk(FN_TICK, t_now, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1));
    drain();
    burn = 90;
    for (int i = 0; i < burn; i++) begin
      wait (word_q.size() < 8);
      push_word(mk(FN_START, t_now, 0, 0, 0, 0, 0, 0, 0, 8'($urandom), 1, 1));
      push_word(mk(FN_TICK, t_now, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0));
    end
    push_word(mk(FN_START, t_now, 0, 0, 0, 0, 0, 0, 0, 10, 1, 1));

    // last part: no idling, a tight failure limit, then fatal health and a bad configuration
    set_config(3, 16'h00FF, 16, 100, 40, 1, 1);
    run_random(100, 0);
    run_random(40, 1);
    set_config(255, 16'h0000, 16, 100, 40, 1, 1);
    run_random(5, 0);

    drain();
    if (outstanding != 0) report("results still pending", outstanding, 0);
    if (errors == 0) begin
      $display("** task_auction_node_controller_core: PASSED **");
    end else begin
      $display("** task_auction_node_controller_core: FAILED **");
    end
    $finish;
  end
endmodule
`default_nettype wire
